>>> hw/rtl/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and constants of the sorted key table: field widths, action
// and status codes, the sequencer states and the per-cell control group.
// ----------------------------------------------------------------------------
package skt_pkg;

   localparam int KEY_W   = 14;
   localparam int CNT_W   = 9;
   localparam int POS_W   = 8;
   localparam int LENF_W  = 9;
   localparam int STAT_W  = 3;
   localparam int ACT_W   = 2;

   localparam logic [KEY_W-1:0] MAX_KEY   = KEY_W'(9999);
   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(256);

   // tree fan-in is 16, so each stage consumes four index bits
   localparam int TREE_RADIX_BITS = 4;

   typedef enum logic [ACT_W-1:0] {
      ACT_INSERT = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_FIND   = 2'd2,
      ACT_READ   = 2'd3
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 3'd0,
      ST_DUP      = 3'd1,
      ST_FULL     = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_INVALID  = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_CMP  = 4'b0010,
      S_TREE = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   // control group broadcast from the sequencer to every cell
   typedef struct packed {
      logic             cmp_en;
      logic             ins_en;
      logic             del_en;
      logic             by_key;
      logic [KEY_W-1:0] key;
      logic [CNT_W-1:0] cnt;
      logic [POS_W-1:0] position;
   } cell_ctl_type;

endpackage

>>> hw/rtl/skt_cell.sv
// ----------------------------------------------------------------------------
// skt_cell
// One slot of the table. Holds a key and a count, compares the key against the
// broadcast operand, and shifts in from either neighbor on insert or delete.
// ----------------------------------------------------------------------------
module skt_cell
   import skt_pkg::*;
#(
   parameter int IDX   = 0,
   parameter int IDX_W = 8,
   parameter int LEN_W = 9,
   parameter int TW    = 1 + IDX_W + KEY_W + CNT_W
) (
   input  logic             clock,
   input  cell_ctl_type     ctl,
   input  logic [LEN_W-1:0] len,
   input  logic [KEY_W-1:0] left_key,
   input  logic [CNT_W-1:0] left_cnt,
   input  logic             left_lt,
   input  logic [KEY_W-1:0] right_key,
   input  logic [CNT_W-1:0] right_cnt,
   output logic [KEY_W-1:0] cell_key,
   output logic [CNT_W-1:0] cell_cnt,
   output logic             cell_lt,
   output logic [TW-1:0]    cell_leaf
);

   logic [KEY_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             lt_ff, lt_in;
   logic             pos_eq_ff, pos_eq_in;
   logic             below_len;
   logic             boundary;
   logic             at_or_after;
   logic             sel;

   assign below_len   = 32'(len) > 32'(IDX);
   assign at_or_after = 32'(IDX) >= 32'(ctl.position);
   // first slot whose key is not below the operand
   assign boundary    = left_lt && !lt_ff;
   assign sel         = ctl.by_key ? boundary : pos_eq_ff;

   always_comb begin
      lt_in     = lt_ff;
      pos_eq_in = pos_eq_ff;
      key_in    = key_ff;
      cnt_in    = cnt_ff;
      if (ctl.cmp_en) begin
         lt_in     = below_len && (key_ff < ctl.key);
         pos_eq_in = 32'(ctl.position) == 32'(IDX);
      end
      if (ctl.ins_en && !lt_ff) begin
         key_in = boundary ? ctl.key : left_key;
         cnt_in = boundary ? ctl.cnt : left_cnt;
      end
      if (ctl.del_en && at_or_after) begin
         key_in = right_key;
         cnt_in = right_cnt;
      end
   end

   always_ff @(posedge clock) begin
      lt_ff     <= lt_in;
      pos_eq_ff <= pos_eq_in;
      key_ff    <= key_in;
      cnt_ff    <= cnt_in;
   end

   assign cell_key  = key_ff;
   assign cell_cnt  = cnt_ff;
   assign cell_lt   = lt_ff;
   assign cell_leaf = sel ? {below_len, IDX_W'(IDX), key_ff, cnt_ff} : '0;

endmodule

>>> hw/rtl/skt_or_tree.sv
// ----------------------------------------------------------------------------
// skt_or_tree
// Registered OR tree with fan-in 16. Collects the single selected cell's
// leaf into one word, one register stage per four index bits.
// ----------------------------------------------------------------------------
module skt_or_tree
   import skt_pkg::*;
#(
   parameter int N      = 256,
   parameter int W      = 32,
   parameter int STAGES = 2
) (
   input  logic                clock,
   input  logic [N-1:0][W-1:0] leaf_in,
   output logic [W-1:0]        root_out
);

   localparam int FAN = 1 << TREE_RADIX_BITS;

   logic [W-1:0] lvl_ff [STAGES][N];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      localparam int SPAN_IN = 1 << (TREE_RADIX_BITS * s);
      localparam int SPAN    = SPAN_IN * FAN;
      localparam int NI      = (N + SPAN_IN - 1) / SPAN_IN;
      localparam int NO      = (N + SPAN - 1) / SPAN;
      for (genvar j = 0; j < NO; j++) begin : g_node
         logic [W-1:0] node;
         if (s == 0) begin : g_leaf
            always_comb begin
               node = '0;
               for (int k = 0; k < FAN; k++) begin
                  if (j * FAN + k < NI) begin
                     node = node | leaf_in[j * FAN + k];
                  end
               end
            end
         end else begin : g_inner
            always_comb begin
               node = '0;
               for (int k = 0; k < FAN; k++) begin
                  if (j * FAN + k < NI) begin
                     node = node | lvl_ff[s-1][j * FAN + k];
                  end
               end
            end
         end
         always_ff @(posedge clock) begin
            lvl_ff[s][j] <= node;
         end
      end
   end

   assign root_out = lvl_ff[STAGES-1][0];

endmodule

>>> hw/rtl/sorted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_key_table
// Table of up to TABLE_DEPTH entries kept in ascending key order, with
// insert, delete at position, find by key and read at position.
// ----------------------------------------------------------------------------
// Each table slot is a cell in a chain; on insert every cell at or above the
// insertion point takes its left neighbor's entry (the cell at the point takes
// the new entry) in the same cycle; on delete every cell from the position up takes its right neighbor's entry.
// One request beat is taken at a time and gives one response beat: it is
// accepted and registered, all cells compare in parallel, each stage of
// the 16-way OR tree gathering the selected cell is registered, then the
// result is decided and the cells shift once the output register is free.
// A finished response waits in the output register while the next request
// beat is taken; the table contents after reset are undefined and only
// slots below the current length are ever reported.
// ----------------------------------------------------------------------------
module sorted_key_table
   import skt_pkg::*;
#(
   parameter int TABLE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // key[13:0], extension_count[22:14], position[30:23]
   input  logic [1:0]  req_tuser,   // action[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // found_position[7:0], found_key[21:8],
                                    // found_count[30:22], table_length[39:31]
   output logic [2:0]  rsp_tuser    // status[2:0]
);

   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int LEN_W       = $clog2(TABLE_DEPTH + 1);
   localparam int TW          = 1 + IDX_W + KEY_W + CNT_W;
   localparam int TREE_STAGES = (IDX_W + TREE_RADIX_BITS - 1) / TREE_RADIX_BITS;
   localparam int TC_W        = $clog2(TREE_STAGES + 1);

   state_type        state_ff, state_in;
   logic [TC_W-1:0]  wait_ff, wait_in;
   logic [LEN_W-1:0] len_ff, len_in;
   action_type       act_ff;
   logic [KEY_W-1:0] key_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [POS_W-1:0] pos_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff;
   logic [POS_W-1:0] rsp_pos_ff;
   logic [KEY_W-1:0] rsp_key_ff;
   logic [CNT_W-1:0] rsp_cnt_ff;
   logic [LENF_W-1:0] rsp_len_ff;

   cell_ctl_type     ctl;
   logic [KEY_W-1:0] key_w [TABLE_DEPTH];
   logic [CNT_W-1:0] cnt_w [TABLE_DEPTH];
   logic             lt_w  [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0][TW-1:0] leaf_w;
   logic [TW-1:0]    root;

   logic             t_hit;
   logic [IDX_W-1:0] t_pos;
   logic [KEY_W-1:0] t_key;
   logic [CNT_W-1:0] t_cnt;

   logic             req_fire;
   logic             done_fire;
   logic             key_ok;
   logic             operand_ok;
   status_type       res_status;
   logic [LEN_W-1:0] res_pos;
   logic [KEY_W-1:0] res_key;
   logic [CNT_W-1:0] res_cnt;
   logic             do_ins;
   logic             do_del;
   logic [31:0]      res_pos_wide;
   logic [31:0]      len_wide;

   assign req_tready = state_ff == S_IDLE;
   assign req_fire   = req_tvalid && req_tready;
   assign done_fire  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      wait_in  = wait_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            state_in = S_TREE;
            wait_in  = TC_W'(TREE_STAGES - 1);
         end
         S_TREE: begin
            if (wait_ff == '0) begin
               state_in = S_DONE;
            end else begin
               wait_in = wait_ff - 1'b1;
            end
         end
         S_DONE: begin
            if (done_fire) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wait_ff  <= '0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         act_ff <= action_type'(req_tuser);
         key_ff <= req_tdata[13:0];
         cnt_ff <= req_tdata[22:14];
         pos_ff <= req_tdata[30:23];
      end
   end

   // ---- chain of cells
   assign ctl.cmp_en   = state_ff == S_CMP;
   assign ctl.ins_en   = done_fire && do_ins;
   assign ctl.del_en   = done_fire && do_del;
   assign ctl.by_key   = (act_ff == ACT_INSERT) || (act_ff == ACT_FIND);
   assign ctl.key      = key_ff;
   assign ctl.cnt      = cnt_ff;
   assign ctl.position = pos_ff;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic [KEY_W-1:0] l_key, r_key;
      logic [CNT_W-1:0] l_cnt, r_cnt;
      logic             l_lt;
      if (i == 0) begin : g_first
         assign l_key = key_ff;
         assign l_cnt = cnt_ff;
         assign l_lt  = 1'b1;
      end else begin : g_mid
         assign l_key = key_w[i-1];
         assign l_cnt = cnt_w[i-1];
         assign l_lt  = lt_w[i-1];
      end
      if (i == TABLE_DEPTH - 1) begin : g_last
         assign r_key = key_w[i];
         assign r_cnt = cnt_w[i];
      end else begin : g_inner
         assign r_key = key_w[i+1];
         assign r_cnt = cnt_w[i+1];
      end
      skt_cell #(
         .IDX   (i),
         .IDX_W (IDX_W),
         .LEN_W (LEN_W),
         .TW    (TW)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .len       (len_ff),
         .left_key  (l_key),
         .left_cnt  (l_cnt),
         .left_lt   (l_lt),
         .right_key (r_key),
         .right_cnt (r_cnt),
         .cell_key  (key_w[i]),
         .cell_cnt  (cnt_w[i]),
         .cell_lt   (lt_w[i]),
         .cell_leaf (leaf_w[i])
      );
   end

   skt_or_tree #(
      .N      (TABLE_DEPTH),
      .W      (TW),
      .STAGES (TREE_STAGES)
   ) u_tree (
      .clock    (clock),
      .leaf_in  (leaf_w),
      .root_out (root)
   );

   assign {t_hit, t_pos, t_key, t_cnt} = root;

   // ---- decision
   assign key_ok     = (key_ff != '0) && (key_ff <= MAX_KEY);
   assign operand_ok = key_ok && (cnt_ff != '0) && (cnt_ff <= MAX_COUNT);

   always_comb begin
      res_status = ST_NOTFOUND;
      res_pos    = '0;
      res_key    = '0;
      res_cnt    = '0;
      do_ins     = 1'b0;
      do_del     = 1'b0;
      len_in     = len_ff;
      unique case (act_ff) inside
         ACT_INSERT: begin
            if (!operand_ok) begin
               res_status = ST_INVALID;
            end else if (t_hit && (t_key == key_ff)) begin
               res_status = ST_DUP;
               res_pos    = LEN_W'(t_pos);
               res_key    = t_key;
               res_cnt    = t_cnt;
            end else if (len_ff == LEN_W'(TABLE_DEPTH)) begin
               res_status = ST_FULL;
            end else begin
               // a miss past the last entry appends at the current length
               res_status = ST_OK;
               res_pos    = t_hit ? LEN_W'(t_pos) : len_ff;
               res_key    = key_ff;
               res_cnt    = cnt_ff;
               do_ins     = 1'b1;
               len_in     = len_ff + 1'b1;
            end
         end
         ACT_DELETE: begin
            if (t_hit) begin
               res_status = ST_OK;
               res_pos    = LEN_W'(t_pos);
               res_key    = t_key;
               res_cnt    = t_cnt;
               do_del     = 1'b1;
               len_in     = len_ff - 1'b1;
            end
         end
         ACT_FIND, ACT_READ: begin
            if (t_hit && ((act_ff == ACT_READ) || (key_ok && (t_key == key_ff)))) begin
               res_status = ST_OK;
               res_pos    = LEN_W'(t_pos);
               res_key    = t_key;
               res_cnt    = t_cnt;
            end
         end
         default: res_status = ST_NOTFOUND;
      endcase
   end

   assign res_pos_wide = 32'(res_pos);
   assign len_wide     = 32'(len_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else if (done_fire) begin
         len_ff <= len_in;
      end
   end

   // ---- output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (done_fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done_fire) begin
         rsp_status_ff <= res_status;
         rsp_pos_ff    <= res_pos_wide[POS_W-1:0];
         rsp_key_ff    <= res_key;
         rsp_cnt_ff    <= res_cnt;
         rsp_len_ff    <= len_wide[LENF_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_len_ff, rsp_cnt_ff, rsp_key_ff, rsp_pos_ff};

   // ---- assertions
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      32'(len_ff) <= 32'(TABLE_DEPTH))
      else $error("table length beyond depth");

   a_len_moves_on_done: assert property (@(posedge clock) disable iff (reset)
      !done_fire |=> $stable(len_ff))
      else $error("table length changed outside completion");

   a_done_gives_beat: assert property (@(posedge clock) disable iff (reset)
      done_fire |=> rsp_tvalid)
      else $error("completed item produced no response beat");

   a_no_ins_and_del: assert property (@(posedge clock) disable iff (reset)
      !(ctl.ins_en && ctl.del_en))
      else $error("insert and delete shift at once");

endmodule
